// ----- rtl/pfse_pkg.sv -----
// ----------------------------------------------------------------------------
// pfse_pkg
// Shared types and constants for the packet descriptor FIFO with serial
// epochs: operation and status codes, the slot record and defaults.
// ----------------------------------------------------------------------------
package pfse_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam logic [7:0]  OVERHEAD_RESET  = 8'd96;

  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned DURATION_W = 32;
  localparam int unsigned STREAM_W   = 8;
  localparam int unsigned SERIAL_W   = 32;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned BYTES_W    = 40;
  localparam int unsigned DUR_TOT_W  = 48;

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_MARKER = 3'd1,
    OP_GET    = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_START  = 3'd4,
    OP_ABORT  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABORTED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // One queue entry as held in the slot memory
  typedef struct packed {
    logic [HANDLE_W-1:0]   handle;
    logic [SIZE_W-1:0]     size;
    logic [DURATION_W-1:0] duration;
    logic [STREAM_W-1:0]   stream;
    logic [SERIAL_W-1:0]   serial;
    logic                  marker;
  } slot_t;

endpackage

// ----- rtl/pfse_slot_ram.sv -----
// ----------------------------------------------------------------------------
// pfse_slot_ram
// Simple dual-port slot memory: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module pfse_slot_ram
  import pfse_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output slot_t         rdata
);

  slot_t mem [DEPTH];

  // Write a slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read a slot, data lands next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/packet_fifo_with_serial_epochs_top.sv -----
// ----------------------------------------------------------------------------
// packet_fifo_with_serial_epochs_top
// Queue of packet descriptors tagged with a serial epoch, with running
// entry count, byte total and duration total.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (op plus packet fields) is taken at a clock edge where
//   start is high and busy is low. Each command gives one result word,
//   shown for exactly one cycle while done is high; the receiver cannot
//   stall it. queued_count, queued_bytes and queued_duration show the
//   totals after the last command and are valid while done is high.
//   A get that pops an entry first reads the slot memory, then does the
//   pop and total update in the pop state; every other command is done
//   straight from idle. busy is high in the pop state, while the slot
//   data comes back, so no new command is taken until a pop's word is
//   out; all other commands can follow each other back to back.
//   cfg_wr_en/cfg_wr_data write the per-entry byte overhead; write it only
//   while the block is idle.
//   Reset (rst, synchronous) empties the queue, clears the totals and the
//   serial, sets the overhead to 96 and leaves the block in the aborted
//   state: puts and gets report aborted until a start command.
//   The slot memory itself is not cleared; only written slots are read.
// ----------------------------------------------------------------------------
module packet_fifo_with_serial_epochs_top
  import pfse_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            op,
  input  logic [HANDLE_W-1:0]   packet_handle,
  input  logic [SIZE_W-1:0]     packet_size,
  input  logic [DURATION_W-1:0] packet_duration,
  input  logic [STREAM_W-1:0]   stream_number,
  output logic                  done,
  output logic [1:0]            status,
  output logic [HANDLE_W-1:0]   out_handle,
  output logic [SIZE_W-1:0]     out_size,
  output logic [DURATION_W-1:0] out_duration,
  output logic [STREAM_W-1:0]   out_stream,
  output logic [SERIAL_W-1:0]   out_serial,
  output logic                  out_is_marker,
  output logic [COUNT_W-1:0]    queued_count,
  output logic [BYTES_W-1:0]    queued_bytes,
  output logic [DUR_TOT_W-1:0]  queued_duration
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t                 state;
  logic [IW-1:0]          head_index;
  logic [IW-1:0]          tail_index;
  logic [CW-1:0]          entry_count;
  logic [BYTES_W-1:0]     byte_total;
  logic [DUR_TOT_W-1:0]   duration_total;
  logic [SERIAL_W-1:0]    serial_counter;
  logic                   abort_flag;
  logic [7:0]             entry_overhead;

  logic                   accept;
  logic                   is_marker_op;
  logic                   is_enq_op;
  logic                   abort_eff;
  logic                   queue_full;
  logic                   enq_go;
  logic                   get_go;
  status_t                enq_status;
  status_t                status_next;
  logic [SERIAL_W-1:0]    serial_next;
  slot_t                  wr_slot;
  slot_t                  rd_slot;
  logic [IW-1:0]          tail_next;
  logic [IW-1:0]          head_next;
  logic [BYTES_W-1:0]     bytes_add;
  logic [BYTES_W-1:0]     bytes_sub;
  logic [CW+COUNT_W-1:0]  count_wide;

  assign busy   = (state == S_POP);
  assign accept = start && !busy;

  // Decode the command and work out the enqueue outcome
  always_comb begin
    is_marker_op = (op == OP_MARKER) || (op == OP_START);
    is_enq_op    = (op == OP_PUT) || is_marker_op;
    abort_eff    = (op == OP_START) ? 1'b0 : abort_flag;
    queue_full   = (entry_count >= CW'(QUEUE_DEPTH));
    if (abort_eff) begin
      enq_status = ST_ABORTED;
    end else if (queue_full) begin
      enq_status = ST_FULL;
    end else begin
      enq_status = ST_OK;
    end
    case (op)
      OP_PUT, OP_MARKER, OP_START: begin
        status_next = enq_status;
      end
      OP_GET: begin
        if (abort_flag) begin
          status_next = ST_ABORTED;
        end else if (entry_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          status_next = ST_OK;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    enq_go = accept && is_enq_op && !abort_eff && !queue_full;
    get_go = accept && (op == OP_GET) && !abort_flag && (entry_count != '0);
    serial_next = serial_counter + (is_marker_op ? SERIAL_W'(1) : SERIAL_W'(0));
    if (is_marker_op) begin
      wr_slot = '{handle: '0, size: '0, duration: '0, stream: '0,
                  serial: serial_next, marker: 1'b1};
    end else begin
      wr_slot = '{handle: packet_handle, size: packet_size,
                  duration: packet_duration, stream: stream_number,
                  serial: serial_counter, marker: 1'b0};
    end
    tail_next = (tail_index == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_index + 1'b1;
    head_next = (head_index == IW'(QUEUE_DEPTH - 1)) ? '0 : head_index + 1'b1;
    bytes_add = BYTES_W'(wr_slot.size) + BYTES_W'(entry_overhead);
    bytes_sub = BYTES_W'(rd_slot.size) + BYTES_W'(entry_overhead);
  end

  pfse_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (enq_go),
    .waddr (tail_index),
    .wdata (wr_slot),
    .re    (get_go),
    .raddr (head_index),
    .rdata (rd_slot)
  );

  // Sequence commands, update pointers and totals, register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head_index     <= '0;
      tail_index     <= '0;
      entry_count    <= '0;
      byte_total     <= '0;
      duration_total <= '0;
      serial_counter <= '0;
      abort_flag     <= 1'b1;
      entry_overhead <= OVERHEAD_RESET;
      done           <= 1'b0;
      status         <= ST_OK;
    end else begin
      if (cfg_wr_en) begin
        entry_overhead <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          // a pop holds its result until the slot read returns
          done <= accept && !get_go;
          if (accept) begin
            out_handle    <= '0;
            out_size      <= '0;
            out_duration  <= '0;
            out_stream    <= '0;
            out_serial    <= '0;
            out_is_marker <= 1'b0;
            status        <= status_next;
            case (op)
              OP_PUT, OP_MARKER, OP_START: begin
                if (op == OP_START) begin
                  abort_flag <= 1'b0;
                end
                if (enq_go) begin
                  serial_counter <= serial_next;
                  tail_index     <= tail_next;
                  entry_count    <= entry_count + 1'b1;
                  byte_total     <= byte_total + bytes_add;
                  duration_total <= duration_total + DUR_TOT_W'(wr_slot.duration);
                end
              end
              OP_GET: begin
                if (get_go) begin
                  state <= S_POP;
                end
              end
              OP_FLUSH: begin
                head_index     <= '0;
                tail_index     <= '0;
                entry_count    <= '0;
                byte_total     <= '0;
                duration_total <= '0;
              end
              OP_ABORT: begin
                abort_flag <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          // pop the head slot and drop its share of the totals
          out_handle     <= rd_slot.handle;
          out_size       <= rd_slot.size;
          out_duration   <= rd_slot.duration;
          out_stream     <= rd_slot.stream;
          out_serial     <= rd_slot.serial;
          out_is_marker  <= rd_slot.marker;
          status         <= ST_OK;
          done           <= 1'b1;
          head_index     <= head_next;
          entry_count    <= entry_count - 1'b1;
          byte_total     <= byte_total - bytes_sub;
          duration_total <= duration_total - DUR_TOT_W'(rd_slot.duration);
          state          <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Totals track the state registers; they are current while done is high
  assign count_wide      = (CW + COUNT_W)'(entry_count);
  assign queued_count    = count_wide[COUNT_W-1:0];
  assign queued_bytes    = byte_total;
  assign queued_duration = duration_total;

endmodule
